// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL, used by tea_queue; they compile away when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define TEA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("tea assertion failed");

// cond at one edge implies prop at the next edge
`define TEA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("tea assertion failed");

`else

`define TEA_ASSERT(label, clk, rst_n, prop)
`define TEA_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: rtl/core/tea_pkg.sv
// Package: TEA cipher constants, item, queue and key types, round sum and mix functions.
`default_nettype none

package tea_pkg;

	localparam int WORD_W = 32;
	localparam int ROUNDS = 32;
	// two half-round stages per Feistel cycle
	localparam int STAGES = 2 * ROUNDS;

	localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam int KEY_IDX_W = 2;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = 2'd0;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = 2'd1;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = 2'd2;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [WORD_W-1:0] k0;
		logic [WORD_W-1:0] k1;
		logic [WORD_W-1:0] k2;
		logic [WORD_W-1:0] k3;
	} key_t;

	typedef struct packed {
		logic              dec;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} blk_t;

	typedef struct packed {
		logic push;
	} q_wr_t;

	typedef struct packed {
		logic empty;
	} q_rd_t;

	// running sum after n additions of DELTA, modulo 2^32
	function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
		logic [WORD_W-1:0] nn;
		nn = WORD_W'(n);
		return WORD_W'(DELTA * nn);
	endfunction

	function automatic logic [WORD_W-1:0] mix(
		input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] sum,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/tea_in_if.sv
// Input channel: command and 64-bit block with valid/ready handshake.
`default_nettype none

interface tea_in_if;
	import tea_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [WORD_W-1:0] first_half;
	logic [WORD_W-1:0] second_half;

	modport source (output valid, command, first_half, second_half, input ready);
	modport sink   (input valid, command, first_half, second_half, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tea_out_if.sv
// Output channel: transformed 64-bit block with valid/ready handshake.
`default_nettype none

interface tea_out_if;
	import tea_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] out_first_half;
	logic [WORD_W-1:0] out_second_half;

	modport source (output valid, out_first_half, out_second_half, input ready);
	modport sink   (input valid, out_first_half, out_second_half, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tea_block_cipher.sv
// A block passes one input hold stage, one queue slot, 64 half-round stages and the
// output register. Throughput: one block per cycle while the output is not held, set
// by the fully unrolled half-round pipeline. The front end keeps taking blocks into
// a 4-entry queue while the output is held, until the queue is full.
// Reset clears all valid flags, the queue and the four key words to zero.
`default_nettype none

module tea_block_cipher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tea_in_if.sink                             req,
	tea_out_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [tea_pkg::KEY_IDX_W-1:0] cfg_index,
	input  wire logic [tea_pkg::WORD_W-1:0]    cfg_data
);
	import tea_pkg::*;

	key_t  key;
	q_wr_t q_wr;
	q_rd_t q_rd;
	blk_t  wr_data;
	blk_t  rd_data;
	logic  q_full;
	logic  pop;

	tea_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_data    (wr_data),
		.key       (key)
	);

	tea_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (wr_data),
		.pop     (pop),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (rd_data)
	);

	tea_rounds u_rounds (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.q_rd   (q_rd),
		.q_data (rd_data),
		.pop    (pop),
		.rsp    (rsp)
	);
endmodule

`default_nettype wire

// File: rtl/core/tea_front.sv
// Front end: key registers, input transfer, command decode and queue push.
`default_nettype none

module tea_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	tea_in_if.sink                               req,
	input  wire logic                            cfg_we,
	input  wire logic [tea_pkg::KEY_IDX_W-1:0]   cfg_index,
	input  wire logic [tea_pkg::WORD_W-1:0]      cfg_data,
	input  wire logic                            q_full,
	output tea_pkg::q_wr_t                       q_wr,
	output tea_pkg::blk_t                        q_data,
	output tea_pkg::key_t                        key
);
	import tea_pkg::*;

	key_t key_q;
	logic hold_vld_q;
	blk_t hold_q;
	logic push;

	assign push      = hold_vld_q && !q_full;
	assign req.ready = !hold_vld_q || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				KEY_IDX_0: key_q.k0 <= cfg_data;
				KEY_IDX_1: key_q.k1 <= cfg_data;
				KEY_IDX_2: key_q.k2 <= cfg_data;
				KEY_IDX_3: key_q.k3 <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
		end else if (req.ready) begin
			hold_vld_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			hold_q.dec <= (req.command == CMD_DECRYPT);
			hold_q.a   <= req.first_half;
			hold_q.b   <= req.second_half;
		end
	end

	assign q_wr.push = push;
	assign q_data    = hold_q;
	assign key       = key_q;
endmodule

`default_nettype wire

// File: rtl/core/tea_queue.sv
// Short FIFO between the front end and the round pipeline.
`default_nettype none
`include "assert_macros.svh"

module tea_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tea_pkg::q_wr_t  wr,
	input  wire tea_pkg::blk_t   wr_data,
	input  wire logic            pop,
	output logic                 full,
	output tea_pkg::q_rd_t       rd,
	output tea_pkg::blk_t        rd_data
);
	import tea_pkg::*;

	blk_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                empty;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data  = mem_q[rd_ptr_q];
	assign rd.empty = empty;

	`TEA_ASSERT(a_no_overflow, clk, arst_n, !(wr.push && full))
	`TEA_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty))
	`TEA_ASSERT(a_count_bound, clk, arst_n, count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
	`TEA_ASSERT_NEXT(a_push_fills, clk, arst_n, wr.push && !pop, !empty)
endmodule

`default_nettype wire

// File: rtl/core/tea_rounds.sv
// Back end: unrolled half-round pipeline with an output register.
`default_nettype none

module tea_rounds (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tea_pkg::key_t  key,
	input  wire tea_pkg::q_rd_t q_rd,
	input  wire tea_pkg::blk_t  q_data,
	output logic                pop,
	tea_out_if.source           rsp
);
	import tea_pkg::*;

	logic              vld_q [STAGES];
	blk_t              stg_q [STAGES];
	blk_t              nxt   [STAGES];
	logic              out_vld_q;
	logic [WORD_W-1:0] out_a_q;
	logic [WORD_W-1:0] out_b_q;
	logic              adv;

	// whole pipeline moves together; it halts only when the output register is held
	assign adv = !out_vld_q || rsp.ready;
	assign pop = adv && !q_rd.empty;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic [WORD_W-1:0] SumEnc = round_sum(i / 2 + 1);
		localparam logic [WORD_W-1:0] SumDec = round_sum(ROUNDS - i / 2);
		localparam logic              Odd    = (i % 2) == 1;

		blk_t              src;
		logic              src_vld;
		logic              upd_b;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] tgt;
		logic [WORD_W-1:0] m;
		logic [WORD_W-1:0] res;

		if (i == 0) begin : g_head
			assign src     = q_data;
			assign src_vld = !q_rd.empty;
		end else begin : g_body
			assign src     = stg_q[i-1];
			assign src_vld = vld_q[i-1];
		end

		// encrypt updates a then b; decrypt undoes b then a
		always_comb begin
			upd_b = Odd ^ src.dec;
			x     = upd_b ? src.a : src.b;
			tgt   = upd_b ? src.b : src.a;
			if (upd_b) begin
				m = mix(x, src.dec ? SumDec : SumEnc, key.k2, key.k3);
			end else begin
				m = mix(x, src.dec ? SumDec : SumEnc, key.k0, key.k1);
			end
			res    = src.dec ? (tgt - m) : (tgt + m);
			nxt[i] = src;
			if (upd_b) begin
				nxt[i].b = res;
			end else begin
				nxt[i].a = res;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (adv) begin
				vld_q[i] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stg_q[i] <= nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_q[STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_a_q <= stg_q[STAGES-1].a;
			out_b_q <= stg_q[STAGES-1].b;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.out_first_half  = out_a_q;
	assign rsp.out_second_half = out_b_q;
endmodule

`default_nettype wire

// File: tb/tb_tea_block_cipher.sv
// Self-checking testbench for tea_block_cipher: predicted TEA blocks against the output stream.
module tb_tea_block_cipher;
	import tea_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
	} halves_t;

	localparam int IDLE_LIMIT       = 2000;
	localparam int TAIL_CYCLES      = 100;
	localparam int PHASES           = 8;
	localparam int RANDOM_PER_PHASE = 180;
	localparam int N_CORNERS        = 7;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [KEY_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	tea_in_if  req_ch();
	tea_out_if rsp_ch();

	tea_block_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	key_t        cipher_key;
	blk_t        blocks_to_send[$];
	halves_t     expected_blocks[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          block_taken;
	int unsigned fail_count;
	int unsigned quiet_cycles;

	function automatic logic [WORD_W-1:0] half_round(input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] sum, input logic [WORD_W-1:0] ka, input logic [WORD_W-1:0] kb);
		return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	endfunction

	function automatic halves_t tea_cipher(input blk_t blk, input key_t k);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] sum;
		a = blk.a;
		b = blk.b;
		sum = '0;
		if (blk.dec == CMD_ENCRYPT) begin
			for (int r = 0; r < ROUNDS; r++) begin
				sum += DELTA;
				a += half_round(b, sum, k.k0, k.k1);
				b += half_round(a, sum, k.k2, k.k3);
			end
		end else begin
			// decryption starts from the sum of the full schedule and walks it back
			for (int r = 0; r < ROUNDS; r++)
				sum += DELTA;
			for (int r = 0; r < ROUNDS; r++) begin
				b -= half_round(a, sum, k.k2, k.k3);
				a -= half_round(b, sum, k.k0, k.k1);
				sum -= DELTA;
			end
		end
		return '{first: a, second: b};
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly encrypt/decrypt round trips, the rest loose blocks of either command
	task automatic add_random_blocks(input int n);
		blk_t    blk;
		halves_t ct;
		bit      have_ct;
		int      pick;
		have_ct = 1'b0;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(9);
			if (pick < 4 && have_ct) begin
				blk.dec = CMD_DECRYPT;
				blk.a = ct.first;
				blk.b = ct.second;
				have_ct = 1'b0;
			end else begin
				blk.dec = (pick < 8) ? CMD_ENCRYPT : CMD_DECRYPT;
				blk.a = pick_word();
				blk.b = pick_word();
				if (blk.dec == CMD_ENCRYPT) begin
					ct = tea_cipher(blk, cipher_key);
					have_ct = 1'b1;
				end
			end
			blocks_to_send.push_back(blk);
		end
	endtask

	task automatic load_key(input key_t k);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= KEY_IDX_0;
		cfg_data <= k.k0;
		@(negedge clk);
		cfg_index <= KEY_IDX_1;
		cfg_data <= k.k1;
		@(negedge clk);
		cfg_index <= KEY_IDX_2;
		cfg_data <= k.k2;
		@(negedge clk);
		cfg_index <= KEY_IDX_3;
		cfg_data <= k.k3;
		@(negedge clk);
		cfg_we <= 1'b0;
		cipher_key = k;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// input driver: holds a block until its transfer, then moves on
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || block_taken)) begin
			if (blocks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.valid <= 1'b1;
				req_ch.command <= blocks_to_send[0].dec;
				req_ch.first_half <= blocks_to_send[0].a;
				req_ch.second_half <= blocks_to_send[0].b;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : monitor
		halves_t want;
		blk_t    sent;
		bit      result_taken;
		block_taken = arst_n && req_ch.valid && req_ch.ready;
		result_taken = arst_n && rsp_ch.valid && rsp_ch.ready;
		if (block_taken) begin
			void'(blocks_to_send.pop_front());
			sent.dec = req_ch.command;
			sent.a = req_ch.first_half;
			sent.b = req_ch.second_half;
			expected_blocks.push_back(tea_cipher(sent, cipher_key));
		end
		if (result_taken) begin
			if (expected_blocks.size() == 0) begin
				$error("result with none expected: out_first_half %h out_second_half %h",
					rsp_ch.out_first_half, rsp_ch.out_second_half);
				fail_count++;
			end else begin
				want = expected_blocks.pop_front();
				if (rsp_ch.out_first_half !== want.first) begin
					$error("out_first_half: expected %h, got %h", want.first,
						rsp_ch.out_first_half);
					fail_count++;
				end
				if (rsp_ch.out_second_half !== want.second) begin
					$error("out_second_half: expected %h, got %h", want.second,
						rsp_ch.out_second_half);
					fail_count++;
				end
			end
		end
		if (!arst_n || block_taken || result_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_tea_block_cipher: FAIL");
			$finish;
		end
	end

	initial begin
		logic [WORD_W-1:0] corner_a[N_CORNERS];
		logic [WORD_W-1:0] corner_b[N_CORNERS];
		blk_t              blk;
		key_t              k;
		corner_a = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'h8000_0000, 32'h0000_0001, 32'haaaa_aaaa};
		corner_b = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
			32'h0000_0001, 32'h8000_0000, 32'h5555_5555};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = KEY_IDX_0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ENCRYPT;
		req_ch.first_half = '0;
		req_ch.second_half = '0;
		rsp_ch.ready = 1'b0;
		cipher_key = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		block_taken = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			// keys change only with nothing in flight
			while (blocks_to_send.size() != 0 || expected_blocks.size() != 0)
				@(posedge clk);
			case (phase)
				0: k = '0; // reset value, not written
				1: k = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
				3: k = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff};
				5: k = '{32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001};
				7: k = '0;
				default: k = '{$urandom, $urandom, $urandom, $urandom};
			endcase
			if (phase != 0)
				load_key(k);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			if (phase == 0) begin
				for (int i = 0; i < N_CORNERS; i++) begin
					blk.a = corner_a[i];
					blk.b = corner_b[i];
					blk.dec = CMD_ENCRYPT;
					blocks_to_send.push_back(blk);
					blk.dec = CMD_DECRYPT;
					blocks_to_send.push_back(blk);
				end
			end
			add_random_blocks(RANDOM_PER_PHASE);
		end

		while (blocks_to_send.size() != 0 || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_tea_block_cipher: PASS");
		else
			$display("tb_tea_block_cipher: FAIL");
		$finish;
	end

endmodule
